// ----- rtl/core/mjpt_pkg.sv -----
// Shared types, constants and codes for the multi-joint PID torque unit.
// Used by the register block, the controller, the datapath and the top level.
// Depends on nothing.
package mjpt_pkg;

    // Default joint count of the top level.
    localparam int JOINTS_DEF = 6;

    // Stream and register port widths.
    localparam int CMD_W     = 2;
    localparam int JOINT_W   = 3;
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 40;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    // Item command codes.
    localparam logic [CMD_W-1:0] CMD_MEAS   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TARGET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GAIN   = 2'd2;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_STEP_TIME  = 3'd0;
    localparam logic [2:0] REG_STEP_RATE  = 3'd1;
    localparam logic [2:0] REG_INTEG_LIM  = 3'd2;
    localparam logic [2:0] REG_DERIV_LIM  = 3'd3;
    localparam logic [2:0] REG_TORQUE_LIM = 3'd4;
    localparam logic [2:0] REG_FF_ENABLE  = 3'd5;
    localparam logic [2:0] REG_CLEAR_LOAD = 3'd6;

    // Register reset values.
    localparam logic [23:0] STEP_TIME_RST = 24'd83886;
    localparam logic [23:0] STEP_RATE_RST = 24'd51200;
    localparam logic [30:0] LIMIT_RST     = 31'd6553600;

    // Controller states, which double as the datapath step codes.
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_WR_TGT    = 4'd1;
    localparam logic [3:0] ST_WR_GAIN   = 4'd2;
    localparam logic [3:0] ST_ERR       = 4'd3;
    localparam logic [3:0] ST_MUL_P     = 4'd4;
    localparam logic [3:0] ST_MUL_DT    = 4'd5;
    localparam logic [3:0] ST_MUL_DIFF  = 4'd6;
    localparam logic [3:0] ST_MUL_INTEG = 4'd7;
    localparam logic [3:0] ST_MUL_XHI   = 4'd8;
    localparam logic [3:0] ST_MUL_XLO   = 4'd9;
    localparam logic [3:0] ST_DSUM      = 4'd10;
    localparam logic [3:0] ST_DCLAMP    = 4'd11;
    localparam logic [3:0] ST_SUM       = 4'd12;
    localparam logic [3:0] ST_OUT       = 4'd13;

    typedef struct packed {
        logic [23:0] step_time;
        logic [23:0] step_rate;
        logic [30:0] integral_limit;
        logic [30:0] derivative_limit;
        logic [30:0] torque_limit;
        logic        ff_enable;
        logic        clear_on_load;
    } t_cfg;

    typedef struct packed {
        logic       capture;
        logic       fire;
        logic [3:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] in_cmd;
        logic             in_joint_ok;
        logic             out_free;
    } t_dp_status;

endpackage

// ----- rtl/core/mjpt_regs.sv -----
// Configuration register file with its APB-style access port.
// Depends on mjpt_pkg for register indexes, reset values and the t_cfg type.
module mjpt_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mjpt_pkg::APB_AW-1:0] paddr,
    input  logic [mjpt_pkg::APB_DW-1:0] pwdata,
    output logic [mjpt_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output mjpt_pkg::t_cfg              o_cfg
);
    import mjpt_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_time        <= STEP_TIME_RST;
            r_cfg.step_rate        <= STEP_RATE_RST;
            r_cfg.integral_limit   <= LIMIT_RST;
            r_cfg.derivative_limit <= LIMIT_RST;
            r_cfg.torque_limit     <= LIMIT_RST;
            r_cfg.ff_enable        <= 1'b1;
            r_cfg.clear_on_load    <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_STEP_TIME:  r_cfg.step_time        <= pwdata[23:0];
                REG_STEP_RATE:  r_cfg.step_rate        <= pwdata[23:0];
                REG_INTEG_LIM:  r_cfg.integral_limit   <= pwdata[30:0];
                REG_DERIV_LIM:  r_cfg.derivative_limit <= pwdata[30:0];
                REG_TORQUE_LIM: r_cfg.torque_limit     <= pwdata[30:0];
                REG_FF_ENABLE:  r_cfg.ff_enable        <= pwdata[0];
                REG_CLEAR_LOAD: r_cfg.clear_on_load    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STEP_TIME:  prdata = {8'd0, r_cfg.step_time};
            REG_STEP_RATE:  prdata = {8'd0, r_cfg.step_rate};
            REG_INTEG_LIM:  prdata = {1'b0, r_cfg.integral_limit};
            REG_DERIV_LIM:  prdata = {1'b0, r_cfg.derivative_limit};
            REG_TORQUE_LIM: prdata = {1'b0, r_cfg.torque_limit};
            REG_FF_ENABLE:  prdata = {31'd0, r_cfg.ff_enable};
            REG_CLEAR_LOAD: prdata = {31'd0, r_cfg.clear_on_load};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/mjpt_ctrl.sv -----
// Sequencing state machine: accepts requests and steps the shared datapath.
// Depends on mjpt_pkg for state codes and the command and status types.
module mjpt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  mjpt_pkg::t_dp_status i_status,
    output mjpt_pkg::t_dp_cmd    o_cmd
);
    import mjpt_pkg::*;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       accept;

    // No request is taken while reset is held.
    assign o_s_tready = (r_state == ST_IDLE) && i_rst_n;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_status.in_joint_ok) begin
                    priority if (i_status.in_cmd == CMD_MEAS) begin
                        n_state = ST_ERR;
                    end else if (i_status.in_cmd == CMD_TARGET) begin
                        n_state = ST_WR_TGT;
                    end else if (i_status.in_cmd == CMD_GAIN) begin
                        n_state = ST_WR_GAIN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_WR_TGT:    n_state = ST_IDLE;
            ST_WR_GAIN:   n_state = ST_IDLE;
            ST_ERR:       n_state = ST_MUL_P;
            ST_MUL_P:     n_state = ST_MUL_DT;
            ST_MUL_DT:    n_state = ST_MUL_DIFF;
            ST_MUL_DIFF:  n_state = ST_MUL_INTEG;
            ST_MUL_INTEG: n_state = ST_MUL_XHI;
            ST_MUL_XHI:   n_state = ST_MUL_XLO;
            ST_MUL_XLO:   n_state = ST_DSUM;
            ST_DSUM:      n_state = ST_DCLAMP;
            ST_DCLAMP:    n_state = ST_SUM;
            ST_SUM:       n_state = ST_OUT;
            ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The final step waits while the previous result is still held downstream.
    assign o_cmd.capture = accept;
    assign o_cmd.fire    = (r_state != ST_OUT) || i_status.out_free;
    assign o_cmd.step    = r_state;

endmodule

// ----- rtl/core/mjpt_dp.sv -----
// Datapath: joint tables, the shared 33x24 multiplier, clamps and the result register.
// Depends on mjpt_pkg for step codes, field widths and the command and status types.
module mjpt_dp #(
    parameter int JOINTS = mjpt_pkg::JOINTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mjpt_pkg::t_cfg                 i_cfg,
    input  mjpt_pkg::t_dp_cmd              i_cmd,
    output mjpt_pkg::t_dp_status           o_status,
    input  logic [mjpt_pkg::CMD_W-1:0]     i_s_tuser,
    input  logic [mjpt_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [mjpt_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import mjpt_pkg::*;

    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    // Per-joint state.
    logic signed [31:0] r_target_tbl [JOINTS];
    logic signed [31:0] r_integ_tbl  [JOINTS];
    logic signed [31:0] r_last_tbl   [JOINTS];
    logic [23:0]        r_kp_tbl     [JOINTS];
    logic [23:0]        r_ki_tbl     [JOINTS];
    logic [23:0]        r_kd_tbl     [JOINTS];

    // Captured request.
    logic [JOINT_W-1:0] r_joint;
    logic [JW-1:0]      r_jidx;
    logic signed [31:0] r_angle;
    logic signed [31:0] r_ff;
    logic [23:0]        r_kp_in;
    logic [23:0]        r_ki_in;
    logic [23:0]        r_kd_in;

    // Working registers.
    logic signed [56:0] r_prod;
    logic signed [31:0] r_err;
    logic signed [32:0] r_diff;
    logic signed [39:0] r_p;
    logic signed [31:0] r_integ;
    logic signed [40:0] r_x;
    logic signed [39:0] r_it;
    logic signed [48:0] r_dhi;
    logic signed [57:0] r_draw;
    logic signed [31:0] r_d;
    logic signed [41:0] r_sum;

    // Result register.
    logic               r_out_valid;
    logic [JOINT_W-1:0] r_out_joint;
    logic signed [31:0] r_torque;

    logic signed [32:0] mul_a;
    logic [23:0]        mul_b;
    logic signed [57:0] mul_full;
    logic signed [32:0] err_wide;
    logic signed [31:0] n_err;
    logic signed [57:0] integ_sum;
    logic signed [31:0] n_integ;
    logic signed [41:0] ff_ext;
    logic               out_load;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_sym(input logic signed [57:0] v,
                                                     input logic [30:0] lim);
        logic signed [57:0] hi;
        logic signed [57:0] lo;
        hi = $signed({27'd0, lim});
        lo = -hi;
        priority if (v > hi) begin
            return hi[31:0];
        end else if (v < lo) begin
            return lo[31:0];
        end else begin
            return v[31:0];
        end
    endfunction

    assign o_status.in_cmd      = i_s_tuser;
    assign o_status.in_joint_ok = (32'(i_s_tdata[2:0]) < JOINTS);
    assign o_status.out_free    = !r_out_valid || i_m_tready;

    // Operand selection for the shared multiplier; the product is registered.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.step)
            ST_MUL_P: begin
                mul_a = {r_err[31], r_err};
                mul_b = r_kp_tbl[r_jidx];
            end
            ST_MUL_DT: begin
                mul_a = {r_err[31], r_err};
                mul_b = i_cfg.step_time;
            end
            ST_MUL_DIFF: begin
                mul_a = r_diff;
                mul_b = r_kd_tbl[r_jidx];
            end
            ST_MUL_INTEG: begin
                mul_a = {r_integ[31], r_integ};
                mul_b = r_ki_tbl[r_jidx];
            end
            ST_MUL_XHI: begin
                mul_a = {{8{r_x[40]}}, r_x[40:16]};
                mul_b = i_cfg.step_rate;
            end
            ST_MUL_XLO: begin
                mul_a = {17'd0, r_x[15:0]};
                mul_b = i_cfg.step_rate;
            end
            default: ;
        endcase
    end

    assign mul_full = mul_a * $signed({1'b0, mul_b});

    assign err_wide = {r_target_tbl[r_jidx][31], r_target_tbl[r_jidx]}
                    - {r_angle[31], r_angle};
    assign n_err    = sat32(err_wide);

    // r_prod holds err*dt here; its floor over 2^24 is bits 55..24.
    assign integ_sum = {{26{r_integ_tbl[r_jidx][31]}}, r_integ_tbl[r_jidx]}
                     + {{26{r_prod[55]}}, r_prod[55:24]};
    assign n_integ   = clamp_sym(integ_sum, i_cfg.integral_limit);

    assign ff_ext   = i_cfg.ff_enable ? {{10{r_ff[31]}}, r_ff} : '0;
    assign out_load = i_cmd.fire && (i_cmd.step == ST_OUT);

    // Tables and result valid: state that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < JOINTS; k++) begin
                r_target_tbl[k] <= '0;
                r_integ_tbl[k]  <= '0;
                r_last_tbl[k]   <= '0;
                r_kp_tbl[k]     <= '0;
                r_ki_tbl[k]     <= '0;
                r_kd_tbl[k]     <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.fire) begin
                unique case (i_cmd.step)
                    ST_WR_TGT: begin
                        r_target_tbl[r_jidx] <= r_angle;
                    end
                    ST_WR_GAIN: begin
                        r_kp_tbl[r_jidx] <= r_kp_in;
                        r_ki_tbl[r_jidx] <= r_ki_in;
                        r_kd_tbl[r_jidx] <= r_kd_in;
                        if (i_cfg.clear_on_load) begin
                            r_integ_tbl[r_jidx] <= '0;
                            r_last_tbl[r_jidx]  <= '0;
                        end
                    end
                    ST_MUL_P:    r_last_tbl[r_jidx]  <= r_err;
                    ST_MUL_DIFF: r_integ_tbl[r_jidx] <= n_integ;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_full[56:0];
        if (i_cmd.capture) begin
            r_joint <= i_s_tdata[2:0];
            r_jidx  <= JW'(i_s_tdata[2:0]);
            r_angle <= i_s_tdata[34:3];
            r_ff    <= i_s_tdata[66:35];
            r_kp_in <= i_s_tdata[90:67];
            r_ki_in <= i_s_tdata[114:91];
            r_kd_in <= i_s_tdata[138:115];
        end
        if (i_cmd.fire) begin
            unique case (i_cmd.step)
                ST_ERR:       r_err   <= n_err;
                ST_MUL_P:     r_diff  <= {r_err[31], r_err}
                                       - {r_last_tbl[r_jidx][31], r_last_tbl[r_jidx]};
                ST_MUL_DT:    r_p     <= r_prod[55:16];
                ST_MUL_DIFF:  r_integ <= n_integ;
                ST_MUL_INTEG: r_x     <= r_prod[56:16];
                ST_MUL_XHI:   r_it    <= r_prod[55:16];
                ST_MUL_XLO:   r_dhi   <= r_prod[48:0];
                // The high part carries weight 2^16, so only the low product is floored.
                ST_DSUM:      r_draw  <= {r_dhi[48], r_dhi, 8'd0}
                                       + {26'd0, r_prod[39:8]};
                ST_DCLAMP:    r_d     <= clamp_sym(r_draw, i_cfg.derivative_limit);
                ST_SUM:       r_sum   <= {{2{r_p[39]}}, r_p} + {{2{r_it[39]}}, r_it}
                                       + {{10{r_d[31]}}, r_d} + ff_ext;
                ST_OUT: begin
                    r_out_joint <= r_joint;
                    r_torque    <= clamp_sym({{16{r_sum[41]}}, r_sum}, i_cfg.torque_limit);
                end
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_torque, r_out_joint};

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_m_tready))
        else $error("result loaded while the previous one was still held");

    a_torque_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_torque <= $signed({1'b0, i_cfg.torque_limit}))
                     && (r_torque >= -$signed({1'b0, i_cfg.torque_limit})))
        else $error("held torque outside the torque limit");

    a_integ_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fire && (i_cmd.step == ST_MUL_DIFF))
        |=> (r_integ <= $signed({1'b0, i_cfg.integral_limit}))
         && (r_integ >= -$signed({1'b0, i_cfg.integral_limit})))
        else $error("integrator update outside the integral limit");

endmodule

// ----- rtl/core/multi_joint_pid_torque_unit.sv -----
// Multi-joint PID torque unit: top level joining registers, controller and datapath.
// A measurement request shows its torque on m_axis after the eleven steps of the shared
// multiplier sequence that follow its acceptance; target and gain requests write their
// table entries and ignored requests do nothing. No new request is taken before the last
// is done, and a held result stalls the last step until m_axis takes the previous torque.
// Reset (synchronous, active low) restores register defaults and zeroes every joint table.
// Depends on mjpt_pkg, mjpt_regs, mjpt_ctrl and mjpt_dp.
module multi_joint_pid_torque_unit #(
    parameter int JOINTS = mjpt_pkg::JOINTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tuser: cmd [1:0].
    input  logic [mjpt_pkg::CMD_W-1:0]     s_axis_tuser,
    // tdata: joint [2:0], angle [34:3], ff_torque [66:35], p_gain [90:67],
    // i_gain [114:91], d_gain [138:115], zero fill [143:139].
    input  logic [mjpt_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: out_joint [2:0], torque [34:3], zero fill [39:35].
    output logic [mjpt_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mjpt_pkg::APB_AW-1:0]    paddr,
    input  logic [mjpt_pkg::APB_DW-1:0]    pwdata,
    output logic [mjpt_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import mjpt_pkg::*;

    // The register block holds dt, 1/dt, the three clamp limits and the two mode bits.
    // Software must write it only while no request is in flight; the block does not enforce this.
    t_cfg       cfg;
    // The controller steps the datapath one operation per cycle while no step stalls; the
    // datapath reports the offered command and joint range and if the result slot is free.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    mjpt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // A request is taken only in the idle state. A measurement then walks through the
    // error, the five gain and rate products (the derivative product split in two halves
    // so one 33x24 multiplier serves every term), the clamps and the final sum.
    mjpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // The result register decouples the two streams: a new request may be taken while a
    // finished torque still waits; only the last step holds until the slot frees up.
    mjpt_dp #(
        .JOINTS (JOINTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .i_s_tuser  (s_axis_tuser),
        .i_s_tdata  (s_axis_tdata),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the multi-joint PID torque unit: streams requests, predicts every torque.
// Depends on mjpt_pkg and the multi_joint_pid_torque_unit top level.
module testbench;
    import mjpt_pkg::*;

    // The bench runs the block at its default joint count.
    localparam int JOINTS      = JOINTS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    // Target and gain requests cause no torque, so the block may still be busy
    // after the last result; this drain comfortably covers a measurement as well.
    localparam int DRAIN_CYCLES = 40;
    // Length of the long receiver hold-off that forces the block to back up.
    localparam int LONG_HOLD = 300;

    // Command code that the block must ignore, and a register slot past the list.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0]       REG_UNUSED = 3'd7;

    typedef logic signed [127:0] wide_t;
    localparam wide_t INT32_MAX_W = 128'sd2147483647;
    localparam wide_t INT32_MIN_W = -(128'sd2147483648);

    // One request on the input stream.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [JOINT_W-1:0] joint;
        logic [31:0]        angle;
        logic [31:0]        ff;
        logic [23:0]        kp, ki, kd;
    } pid_req_t;

    // One torque result on the output stream.
    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [31:0]        torque;
    } torque_res_t;

    // Clock, reset and every block input start at a known value.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [CMD_W-1:0]     s_axis_tuser = '0;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // Requests waiting to be offered, and torques the block still owes us.
    pid_req_t    request_queue[$];
    torque_res_t torque_queue[$];

    // Predicted register contents, kept in step with every configuration write.
    logic [23:0] cfg_step_time  = STEP_TIME_RST;
    logic [23:0] cfg_step_rate  = STEP_RATE_RST;
    logic [30:0] cfg_integ_lim  = LIMIT_RST;
    logic [30:0] cfg_deriv_lim  = LIMIT_RST;
    logic [30:0] cfg_torque_lim = LIMIT_RST;
    logic        cfg_ff_en      = 1'b1;
    logic        cfg_clear_load = 1'b1;

    // Predicted per-joint tables; all of them come out of reset as zero.
    logic [31:0] target_tab [JOINTS] = '{default: '0};
    logic [31:0] integ_tab  [JOINTS] = '{default: '0};
    logic [31:0] last_tab   [JOINTS] = '{default: '0};
    logic [23:0] p_tab      [JOINTS] = '{default: '0};
    logic [23:0] i_tab      [JOINTS] = '{default: '0};
    logic [23:0] d_tab      [JOINTS] = '{default: '0};

    // Targets handed out by the generator, so measurements can land close to them.
    logic [31:0] planned_target [8] = '{default: '0};

    // Phase control shared between the sequencer and the two stream processes.
    bit quiet_phase  = 1'b0;
    bit hold_request = 1'b0;

    int       gap_left = 0;
    int       hold_left = 0;
    pid_req_t offered;
    int       cycle_count = 0;
    int       mismatch_count = 0;
    int       n_meas = 0, n_target = 0, n_gain = 0, n_ignored = 0;
    int       n_checked = 0, n_settings = 0;

    multi_joint_pid_torque_unit #(.JOINTS(JOINTS)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Symmetric clamp to +-lim. The limit is unsigned, so it zero-extends.
    function automatic wide_t clamp_sym(wide_t v, logic [30:0] lim);
        wide_t l;
        l = wide_t'(lim);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    // Applies one accepted request to the predicted joint state and, for a
    // measurement, queues the torque the block must produce. All arithmetic is done
    // at 128 bits, so every product is exact and >>> gives floor rounding.
    function automatic void predict_torque(pid_req_t r);
        logic [JOINT_W-1:0] j;
        wide_t err, tgt, prev, gain, scale, p, integ, itq, diff, x, d, sum, ffw;
        j = r.joint;
        if (j >= JOINTS) begin
            n_ignored++;
            return;
        end
        case (r.cmd)
            CMD_TARGET: begin
                target_tab[j] = r.angle;
                n_target++;
            end
            CMD_GAIN: begin
                p_tab[j] = r.kp;
                i_tab[j] = r.ki;
                d_tab[j] = r.kd;
                if (cfg_clear_load) begin
                    integ_tab[j] = '0;
                    last_tab[j] = '0;
                end
                n_gain++;
            end
            CMD_MEAS: begin
                // Error is saturated to 32 bits before any use.
                err = wide_t'($signed(r.angle));
                tgt = wide_t'($signed(target_tab[j]));
                err = tgt - err;
                if (err > INT32_MAX_W) err = INT32_MAX_W;
                else if (err < INT32_MIN_W) err = INT32_MIN_W;

                gain = wide_t'(p_tab[j]);
                p = (err * gain) >>> 16;

                // The integrator clamp is the anti-windup limit.
                scale = wide_t'(cfg_step_time);
                integ = wide_t'($signed(integ_tab[j]));
                integ = clamp_sym(integ + ((err * scale) >>> 24), cfg_integ_lim);
                integ_tab[j] = integ[31:0];
                gain = wide_t'(i_tab[j]);
                itq = (integ * gain) >>> 16;

                // A zero rate makes the derivative term vanish on its own.
                prev = wide_t'($signed(last_tab[j]));
                diff = err - prev;
                gain = wide_t'(d_tab[j]);
                x = (diff * gain) >>> 16;
                scale = wide_t'(cfg_step_rate);
                d = clamp_sym((x * scale) >>> 8, cfg_deriv_lim);
                last_tab[j] = err[31:0];

                sum = p + itq + d;
                if (cfg_ff_en) begin
                    ffw = wide_t'($signed(r.ff));
                    sum = sum + ffw;
                end
                sum = clamp_sym(sum, cfg_torque_lim);
                torque_queue.push_back('{joint: j, torque: sum[31:0]});
                n_meas++;
            end
            default: n_ignored++;
        endcase
    endfunction

    function automatic pid_req_t make_request(logic [CMD_W-1:0] cmd, logic [JOINT_W-1:0] joint,
                                              logic [31:0] angle, logic [31:0] ff,
                                              logic [23:0] kp, logic [23:0] ki,
                                              logic [23:0] kd);
        pid_req_t r;
        r = '{cmd: cmd, joint: joint, angle: angle, ff: ff, kp: kp, ki: ki, kd: kd};
        return r;
    endfunction

    // Mostly short gaps, now and then a long one, none in a quiet phase.
    function automatic int pick_gap();
        int roll;
        if (quiet_phase) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [23:0] pick_gain();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 24'($urandom_range(0, 1 << 18));
        if (roll < 85) return 24'($urandom);
        return (roll < 92) ? 24'h000000 : 24'hFFFFFF;
    endfunction

    function automatic logic [31:0] pick_wide(int half_span);
        int roll;
        int offset;
        roll = $urandom_range(0, 99);
        offset = int'($urandom_range(0, 2 * half_span)) - half_span;
        if (roll < 50) return offset;
        if (roll < 85) return $urandom;
        return (roll < 92) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    // Limits spread over tight, working and full-scale values; the upper bit
    // of a full random word checks that the block masks it.
    function automatic logic [31:0] pick_limit();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25) return $urandom_range(0, 65536);
        if (roll < 70) return $urandom_range(1 << 20, 1 << 26);
        return $urandom;
    endfunction

    // Random content in mostly well-formed requests: measurements dominate so the
    // integrator and derivative history get deep, with a little noise mixed in.
    function automatic pid_req_t random_request(bit meas_only);
        pid_req_t r;
        int roll;
        int offset;
        roll = meas_only ? 0 : $urandom_range(0, 99);
        r = make_request(CMD_MEAS, JOINT_W'($urandom_range(0, JOINTS - 1)), $urandom,
                         pick_wide(1 << 18), pick_gain(), pick_gain(), pick_gain());
        if (roll < 65) begin
            offset = int'($urandom_range(0, 1 << 19)) - (1 << 18);
            if ($urandom_range(0, 99) < 60) r.angle = planned_target[r.joint] + offset;
            else r.angle = pick_wide(1 << 22);
        end else if (roll < 80) begin
            r.cmd = CMD_TARGET;
            r.angle = pick_wide(1 << 22);
            planned_target[r.joint] = r.angle;
        end else if (roll < 92) begin
            r.cmd = CMD_GAIN;
        end else if (roll < 96) begin
            r.cmd = CMD_UNUSED;
            r.joint = JOINT_W'($urandom);
        end else begin
            r.cmd = CMD_W'($urandom);
            r.joint = JOINT_W'($urandom_range(JOINTS, 7));
        end
        return r;
    endfunction

    // Request driver: offers the head of the queue and keeps tvalid high for
    // back-to-back requests; each accepted request goes straight to the predictor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_torque(offered);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    offered = request_queue.pop_front();
                    s_axis_tuser  <= offered.cmd;
                    s_axis_tdata  <= {5'b0, offered.kd, offered.ki, offered.kp,
                                      offered.ff, offered.angle, offered.joint};
                    s_axis_tvalid <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks every accepted torque against the oldest prediction
    // and stalls the output at random, or for one long stretch on request.
    always @(posedge i_clk) begin
        torque_res_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_checked++;
                if (torque_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual joint %0d torque %h",
                             $time, m_axis_tdata[2:0], m_axis_tdata[34:3]);
                    mismatch_count++;
                end else begin
                    want = torque_queue.pop_front();
                    if (m_axis_tdata[2:0] !== want.joint) begin
                        $display("%0t: joint mismatch, expected %0d, actual %0d",
                                 $time, want.joint, m_axis_tdata[2:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[34:3] !== want.torque) begin
                        $display("%0t: torque mismatch on joint %0d, expected %h, actual %h",
                                 $time, want.joint, want.torque, m_axis_tdata[34:3]);
                        mismatch_count++;
                    end
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 99) < 6) begin
                hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Waits at falling edges, clear of the stream processes, until nothing is
    // queued, offered or owed, then lets the block run dry.
    task automatic wait_idle();
        @(negedge i_clk);
        while (request_queue.size() != 0 || s_axis_tvalid || torque_queue.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One register write: setup cycle, access cycle, then release once pready is seen.
    task automatic apb_write(input logic [2:0] index, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // The block keeps only the register's own width.
        case (index)
            REG_STEP_TIME:  cfg_step_time  = value[23:0];
            REG_STEP_RATE:  cfg_step_rate  = value[23:0];
            REG_INTEG_LIM:  cfg_integ_lim  = value[30:0];
            REG_DERIV_LIM:  cfg_deriv_lim  = value[30:0];
            REG_TORQUE_LIM: cfg_torque_lim = value[30:0];
            REG_FF_ENABLE:  cfg_ff_en      = value[0];
            REG_CLEAR_LOAD: cfg_clear_load = value[0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [31:0] st, input logic [31:0] sr,
                                input logic [31:0] il, input logic [31:0] dl,
                                input logic [31:0] tl, input logic [31:0] ff,
                                input logic [31:0] cl);
        apb_write(REG_STEP_TIME, st);
        apb_write(REG_STEP_RATE, sr);
        apb_write(REG_INTEG_LIM, il);
        apb_write(REG_DERIV_LIM, dl);
        apb_write(REG_TORQUE_LIM, tl);
        apb_write(REG_FF_ENABLE, ff);
        apb_write(REG_CLEAR_LOAD, cl);
        n_settings++;
    endtask

    task automatic write_random_config();
        logic [31:0] st, sr;
        st = $urandom_range(0, 1) ? $urandom : $urandom_range(40000, 170000);
        sr = $urandom_range(0, 1) ? $urandom : $urandom_range(25000, 110000);
        write_config(st, sr, pick_limit(), pick_limit(), pick_limit(),
                     $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    task automatic queue_random(input int count, input bit meas_only);
        @(negedge i_clk);
        repeat (count) request_queue.push_back(random_request(meas_only));
    endtask

    // Sequencer: reset, a directed opening under the reset defaults, then random
    // phases under several register settings, the extremes among them.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        n_settings = 1;
        @(negedge i_clk);

        // Joint 1 has never had gains loaded, so only feedforward reaches the output.
        request_queue.push_back(make_request(CMD_MEAS, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
        request_queue.push_back(make_request(CMD_MEAS, 1, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
        // Full-scale target and gains drive error saturation and every clamp.
        request_queue.push_back(make_request(CMD_TARGET, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_GAIN, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF,
                                             24'hFFFFFF));
        request_queue.push_back(make_request(CMD_MEAS, 0, 32'h8000_0000, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_MEAS, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_TARGET, 5, 32'h8000_0000, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_GAIN, 5, 0, 0, 24'h010000, 24'h008000,
                                             24'h000100));
        request_queue.push_back(make_request(CMD_MEAS, 5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
        request_queue.push_back(make_request(CMD_MEAS, 5, 32'h8000_0100, 0, 0, 0, 0));
        // Joints past the table and the unused command change nothing.
        request_queue.push_back(make_request(CMD_TARGET, 6, 32'h1234_5678, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_GAIN, 7, 0, 0, 24'hFFFFFF, 24'hFFFFFF,
                                             24'hFFFFFF));
        request_queue.push_back(make_request(CMD_MEAS, 6, 0, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_MEAS, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
        request_queue.push_back(make_request(CMD_UNUSED, 0, 32'h0001_0000, 0, 24'hFFFFFF, 0, 0));
        request_queue.push_back(make_request(CMD_UNUSED, 7, 0, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_MEAS, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
        // Zero gains with the clear enabled empty the history of joint 0.
        request_queue.push_back(make_request(CMD_GAIN, 0, 0, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_MEAS, 0, 0, 32'h1234_5678, 0, 0, 0));
        // A small, ordinary control loop on joint 3.
        request_queue.push_back(make_request(CMD_TARGET, 3, 32'h0001_0000, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_GAIN, 3, 0, 0, 24'h020000, 24'h010000,
                                             24'h008000));
        request_queue.push_back(make_request(CMD_MEAS, 3, 32'h0000_C000, 32'hFFFF_0000, 0, 0, 0));
        request_queue.push_back(make_request(CMD_MEAS, 3, 32'h0000_8000, 0, 0, 0, 0));
        request_queue.push_back(make_request(CMD_MEAS, 3, 32'h0001_4000, 32'h0000_8000, 0, 0, 0));

        // Every register at its largest value, written with all bits set so the
        // masking shows; the slot past the list is written too and must do nothing.
        wait_idle();
        write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        queue_random(100, 1'b0);

        // Every register at zero: no integration, no derivative, no feedforward,
        // no clear on gain load, and a torque limit of zero. No idling on either side.
        wait_idle();
        write_config(0, 0, 0, 0, 0, 0, 0);
        @(negedge i_clk);
        quiet_phase = 1'b1;
        queue_random(80, 1'b0);
        wait_idle();
        quiet_phase = 1'b0;

        // The receiver holds off for a long stretch while measurements keep coming,
        // so the block backs up and must stall its input.
        write_random_config();
        @(negedge i_clk);
        quiet_phase = 1'b1;
        hold_request = 1'b1;
        queue_random(40, 1'b1);
        wait_idle();
        quiet_phase = 1'b0;

        for (int phase = 0; phase < 5; phase++) begin
            wait_idle();
            write_random_config();
            queue_random(100, 1'b0);
        end

        wait_idle();
        $display("Covered %0d measurements, %0d target loads, %0d gain loads, %0d ignored",
                 n_meas, n_target, n_gain, n_ignored);
        $display("requests under %0d register settings; %0d torque results checked.",
                 n_settings, n_checked);
        if (mismatch_count == 0 && torque_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- multi_joint_pid_torque_unit.f -----
rtl/core/mjpt_pkg.sv
rtl/core/mjpt_regs.sv
rtl/core/mjpt_ctrl.sv
rtl/core/mjpt_dp.sv
rtl/core/multi_joint_pid_torque_unit.sv
tb/testbench.sv
